[sv/dfas_pkg.sv]
package dfas_pkg;

    localparam int ExpW  = 11;
    localparam int FracW = 52;
    localparam int MantW = 56;   // hidden bit, 52 fraction bits, guard, round, sticky
    localparam int SumW  = 57;   // one carry bit above the mantissa
    localparam int ShW   = 6;

    localparam logic [ExpW-1:0] ExpMax   = 11'h7FF;
    localparam logic [63:0]     QnanBits = 64'h7FF8_0000_0000_0000;

    // Control that travels beside the mantissa through the pipeline.
    typedef struct packed {
        logic        valid;
        logic        special;    // result is fully known, carried in the bypass word
        logic [63:0] bypass;
        logic        sign;
        logic [12:0] exp;        // working exponent, room for a carry
    } t_ctl;

    // Counts leading zeros of a 57-bit word. A priority scan over independent
    // bit positions, no chain of dependent arithmetic.
    function automatic logic [ShW:0] lzc57(input logic [SumW-1:0] v);
        logic [ShW:0] n;
        logic         found;
        n = 7'd57;
        found = 1'b0;
        for (int i = SumW - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 7'(SumW - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[sv/dfas_align.sv]
// Stage one: special operands, operand swap and alignment with sticky bit.
module dfas_align (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_req_type,
    input  logic [63:0]              i_operand_a,
    input  logic [63:0]              i_operand_b,
    output dfas_pkg::t_ctl           o_ctl,
    output logic                     o_sub,
    output logic [dfas_pkg::MantW-1:0] o_ma,
    output logic [dfas_pkg::MantW-1:0] o_mb
);
    logic [63:0] b;
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
    logic [10:0] ea_raw, eb_raw, ea, eb, diff;
    logic [dfas_pkg::MantW-1:0] ma, mb, big, lit, shifted, lost_mask;
    logic        sticky;
    dfas_pkg::t_ctl n_ctl, r_ctl;
    logic        r_sub;
    logic [dfas_pkg::MantW-1:0] r_ma, r_mb;

    always_comb begin
        b      = {i_operand_b[63] ^ i_req_type, i_operand_b[62:0]};
        sa     = i_operand_a[63];
        sb     = b[63];
        ea_raw = i_operand_a[62:52];
        eb_raw = b[62:52];
        a_nan  = (ea_raw == dfas_pkg::ExpMax) && (i_operand_a[51:0] != '0);
        b_nan  = (eb_raw == dfas_pkg::ExpMax) && (b[51:0] != '0);
        a_inf  = (ea_raw == dfas_pkg::ExpMax) && (i_operand_a[51:0] == '0);
        b_inf  = (eb_raw == dfas_pkg::ExpMax) && (b[51:0] == '0);
        a_zero = (i_operand_a[62:0] == '0);
        b_zero = (b[62:0] == '0);
        ea     = (ea_raw == '0) ? 11'd1 : ea_raw;
        eb     = (eb_raw == '0) ? 11'd1 : eb_raw;
        ma     = {(ea_raw != '0), i_operand_a[51:0], 3'b000};
        mb     = {(eb_raw != '0), b[51:0], 3'b000};
        swap   = eb > ea;
        big    = swap ? mb : ma;
        lit    = swap ? ma : mb;
        diff   = swap ? (eb - ea) : (ea - eb);

        lost_mask = '0;
        if (diff >= 11'(dfas_pkg::MantW)) begin
            shifted = '0;
            sticky  = (lit != '0);
        end else begin
            lost_mask = ~({dfas_pkg::MantW{1'b1}} << diff[5:0]);
            shifted   = lit >> diff[5:0];
            sticky    = (lit & lost_mask) != '0;
        end

        n_ctl.valid   = i_valid;
        n_ctl.special = 1'b1;
        n_ctl.sign    = swap ? sb : sa;
        n_ctl.exp     = {2'b00, swap ? eb : ea};
        if (a_nan) begin
            n_ctl.bypass = i_operand_a;
        end else if (a_inf) begin
            n_ctl.bypass = (b_nan) ? b : ((b_inf && sa != sb) ? dfas_pkg::QnanBits
                                                                : i_operand_a);
        end else if (eb_raw == dfas_pkg::ExpMax) begin
            n_ctl.bypass = b;
        end else if (a_zero) begin
            n_ctl.bypass = b_zero ? {sa & sb, 63'd0} : b;
        end else if (b_zero) begin
            n_ctl.bypass = i_operand_a;
        end else begin
            n_ctl.bypass  = '0;
            n_ctl.special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.special <= n_ctl.special;
        r_ctl.bypass  <= n_ctl.bypass;
        r_ctl.sign    <= n_ctl.sign;
        r_ctl.exp     <= n_ctl.exp;
        r_sub         <= sa ^ sb;
        r_ma          <= big;
        r_mb          <= {shifted[dfas_pkg::MantW-1:1], shifted[0] | sticky};
    end

    assign o_ctl = r_ctl;
    assign o_sub = r_sub;
    assign o_ma  = r_ma;
    assign o_mb  = r_mb;
endmodule

[sv/dfas_addsub.sv]
// Stage two: magnitude add or subtract and leading zero count.
module dfas_addsub (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfas_pkg::t_ctl             i_ctl,
    input  logic                       i_sub,
    input  logic [dfas_pkg::MantW-1:0] i_ma,
    input  logic [dfas_pkg::MantW-1:0] i_mb,
    output dfas_pkg::t_ctl             o_ctl,
    output logic [dfas_pkg::SumW-1:0]  o_sum,
    output logic [dfas_pkg::ShW:0]     o_lz
);
    logic [dfas_pkg::SumW-1:0] a, b, s, diff_ab, diff_ba;
    logic                      sign;
    dfas_pkg::t_ctl            n_ctl, r_ctl;
    logic [dfas_pkg::SumW-1:0] r_sum;
    logic [dfas_pkg::ShW:0]    r_lz;

    always_comb begin
        a       = {1'b0, i_ma};
        b       = {1'b0, i_mb};
        diff_ab = a - b;
        diff_ba = b - a;
        sign    = i_ctl.sign;
        if (!i_sub) begin
            s = a + b;
        end else if (a >= b) begin
            s = diff_ab;
        end else begin
            // Only reachable with equal exponents, where the smaller operand won the swap.
            s    = diff_ba;
            sign = ~i_ctl.sign;
        end
        n_ctl      = i_ctl;
        n_ctl.sign = sign;
        if (!i_ctl.special && s == '0) begin
            n_ctl.special = 1'b1;
            n_ctl.bypass  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.special <= n_ctl.special;
        r_ctl.bypass  <= n_ctl.bypass;
        r_ctl.sign    <= n_ctl.sign;
        r_ctl.exp     <= n_ctl.exp;
        r_sum         <= s;
        r_lz          <= dfas_pkg::lzc57(s);
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;
    assign o_lz  = r_lz;
endmodule

[sv/dfas_norm.sv]
// Stage three: normalization shift limited by the minimum exponent.
module dfas_norm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dfas_pkg::t_ctl            i_ctl,
    input  logic [dfas_pkg::SumW-1:0] i_sum,
    input  logic [dfas_pkg::ShW:0]    i_lz,
    output dfas_pkg::t_ctl            o_ctl,
    output logic [dfas_pkg::MantW-1:0] o_m
);
    logic [dfas_pkg::MantW-1:0] m;
    logic [12:0]                e, room, sh;
    dfas_pkg::t_ctl             n_ctl, r_ctl;
    logic [dfas_pkg::MantW-1:0] r_m;

    always_comb begin
        n_ctl = i_ctl;
        m     = i_sum[dfas_pkg::MantW-1:0];
        e     = i_ctl.exp;
        room  = '0;
        sh    = '0;
        if (i_sum[dfas_pkg::SumW-1]) begin
            m = {i_sum[dfas_pkg::SumW-1:2], i_sum[1] | i_sum[0]};
            e = i_ctl.exp + 13'd1;
        end else begin
            // Leading zeros above the hidden bit position, capped so exp stays at 1.
            room = i_ctl.exp - 13'd1;
            sh   = {6'd0, i_lz} - 13'd1;
            if (sh > room) begin
                sh = room;
            end
            m = i_sum[dfas_pkg::MantW-1:0] << sh[5:0];
            e = i_ctl.exp - sh;
        end
        n_ctl.exp = e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.special <= n_ctl.special;
        r_ctl.bypass  <= n_ctl.bypass;
        r_ctl.sign    <= n_ctl.sign;
        r_ctl.exp     <= n_ctl.exp;
        r_m           <= m;
    end

    assign o_ctl = r_ctl;
    assign o_m   = r_m;
endmodule

[sv/dfas_round.sv]
// Stage four: round to nearest even, overflow and packing.
module dfas_round (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfas_pkg::t_ctl             i_ctl,
    input  logic [dfas_pkg::MantW-1:0] i_m,
    output logic                       o_valid,
    output logic [63:0]                o_bits
);
    logic [2:0]  low;
    logic [53:0] m;
    logic [12:0] e, field;
    logic [63:0] n_bits, r_bits;
    logic        r_valid;

    always_comb begin
        low = i_m[2:0];
        m   = {1'b0, i_m[dfas_pkg::MantW-1:3]};
        e   = i_ctl.exp;
        if (low > 3'd4 || (low == 3'd4 && m[0])) begin
            m = m + 54'd1;
        end
        if (m[53]) begin
            m = m >> 1;
            e = e + 13'd1;
        end
        field = m[52] ? e : 13'd0;
        if (i_ctl.special) begin
            n_bits = i_ctl.bypass;
        end else if (field >= {2'b00, dfas_pkg::ExpMax}) begin
            n_bits = {i_ctl.sign, dfas_pkg::ExpMax, 52'd0};
        end else begin
            n_bits = {i_ctl.sign, field[10:0], m[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_bits <= n_bits;
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;
endmodule

[sv/double_float_add_sub.sv]
// Binary64 adder and subtractor, rounding to nearest even.
//
// Command channel: drive i_req_type, i_operand_a and i_operand_b with start
// high; the word is taken at that clock edge when busy is low. busy is tied
// low because the pipeline never needs to refuse a word, so one word may be
// issued on every cycle.
//
// Result channel: o_sum_bits is valid for exactly one cycle while o_done is high.
// Results leave in issue order; alignment,
// magnitude add with leading zero count, normalization, and rounding with packing
// are each one register stage. Throughput is one word per cycle, set by the
// fully pipelined datapath.
//
// The receiver cannot stall; it must take each result in its strobe cycle.
// A synchronous active-low reset clears every valid bit, so no strobe appears
// for words in flight at reset. NaN, infinity and zero operands are resolved in
// the first stage and ride along the pipe as a finished bypass word.
module double_float_add_sub (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_done,
    output logic [63:0] o_sum_bits
);
    dfas_pkg::t_ctl             ctl1, ctl2, ctl3;
    logic                       sub1;
    logic [dfas_pkg::MantW-1:0] ma1, mb1, m3;
    logic [dfas_pkg::SumW-1:0]  sum2;
    logic [dfas_pkg::ShW:0]     lz2;

    assign busy = 1'b0;

    dfas_align u_align (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start & ~busy),
        .i_req_type(i_req_type), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_ctl(ctl1), .o_sub(sub1), .o_ma(ma1), .o_mb(mb1)
    );

    dfas_addsub u_addsub (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl1), .i_sub(sub1),
        .i_ma(ma1), .i_mb(mb1), .o_ctl(ctl2), .o_sum(sum2), .o_lz(lz2)
    );

    dfas_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl2), .i_sum(sum2), .i_lz(lz2),
        .o_ctl(ctl3), .o_m(m3)
    );

    dfas_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl3), .i_m(m3),
        .o_valid(o_done), .o_bits(o_sum_bits)
    );
endmodule

[sv/dfas_checker.sv]
module dfas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_req_type,
    input logic [63:0] i_operand_a,
    input logic [63:0] i_operand_b,
    input logic        o_done,
    input logic [63:0] o_sum_bits
);
    // A strobe for each accepted word, and never otherwise.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("missing result strobe");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(start && !busy) && $past(i_rst_n) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4)) |-> ##4 !o_done)
        else $error("spurious result strobe");
    // A NaN first operand comes out unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operand_a[62:52] == 11'h7FF && i_operand_a[51:0] != '0)
        |-> ##4 (o_sum_bits == $past(i_operand_a, 4)))
        else $error("NaN not passed through");
    // Adding a value to itself negated cancels to +0.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type && i_operand_a == i_operand_b
         && i_operand_a[62:52] != 11'h7FF)
        |-> ##4 (o_sum_bits == 64'd0))
        else $error("cancellation not +0");
    assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("strobe after reset");
endmodule

bind double_float_add_sub dfas_checker u_dfas_checker (.*);

[dv/tb_double_float_add_sub.sv]
`timescale 1ns / 100ps

module tb_double_float_add_sub;

    // Clock and reset. The reset is synchronous and active low.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // Command side of the adder.
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic [63:0] i_operand_a = 64'd0;
    logic [63:0] i_operand_b = 64'd0;

    // Result side. Each result is on the ports for one cycle only.
    logic        o_done;
    logic [63:0] o_sum_bits;

    localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FracMask  = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
    localparam int          GrsBits   = 3;

    // The two operations that i_req_type selects.
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_op;

    // One row of the directed table. When has_sum is set the row carries the
    // sum that the row is known to give; otherwise the predictor decides.
    typedef struct {
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
        logic        has_sum;
        logic [63:0] sum;
    } t_row;

    logic [63:0] pending_sums[$];
    int          fail_count = 0;

    double_float_add_sub dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_done      (o_done),
        .o_sum_bits  (o_sum_bits)
    );

    always #6 i_clk = ~i_clk;

    // Shift right, folding every bit that falls off into the sticky bit.
    function automatic logic [63:0] shift_sticky(input logic [63:0] m, input int n);
        if (n <= 0) begin
            return m;
        end
        if (n >= 64) begin
            return {63'd0, m != 64'd0};
        end
        return (m >> n) | {63'd0, (m << (64 - n)) != 64'd0};
    endfunction

    // Normalizes a working mantissa with three extra bits, rounds it to
    // nearest even and packs the binary64 word.
    function automatic logic [63:0] round_to_word(input logic [63:0] sign, input int ex,
                                                 input logic [63:0] m);
        logic [63:0] top;
        logic [63:0] low;
        logic [63:0] field;
        top = HiddenBit << GrsBits;
        if (m >= (top << 1)) begin
            m = (m >> 1) | (m & 64'd1);
            ex++;
        end
        while (m < top && ex > 1) begin
            m = m << 1;
            ex--;
        end
        low = m & 64'd7;
        m = m >> GrsBits;
        if (low > 64'd4 || (low == 64'd4 && m[0])) begin
            m++;
        end
        if (m >= (HiddenBit << 1)) begin
            m = m >> 1;
            ex++;
        end
        field = (m & HiddenBit) != 0 ? 64'(ex) : 64'd0;
        if (field >= 64'h7FF) begin
            return sign | (64'h7FF << 52);
        end
        return sign | (field << 52) | (m & FracMask);
    endfunction

    // Predicts the sum word for one command word.
    function automatic logic [63:0] predict_sum(input t_op op, input logic [63:0] a,
                                               input logic [63:0] b_in);
        logic [63:0] b;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mr;
        logic [63:0] sr;
        int          ea;
        int          eb;
        int          er;
        b = (op == OP_SUB) ? (b_in ^ SignBit) : b_in;
        sa = a & SignBit;
        sb = b & SignBit;
        ea = int'(a[62:52]);
        eb = int'(b[62:52]);
        ma = a & FracMask;
        mb = b & FracMask;
        // NaN and infinity operands, with the first operand checked first.
        if (ea == 'h7FF) begin
            if (ma != 0) return a;
            if (eb == 'h7FF) begin
                if (mb != 0) return b;
                if (sa != sb) return 64'h7FF8_0000_0000_0000;
            end
            return a;
        end
        if (eb == 'h7FF) return b;
        // Zero operands.
        if (ea == 0 && ma == 0) begin
            if (eb == 0 && mb == 0) return (sa != 0 && sb != 0) ? SignBit : 64'd0;
            return b;
        end
        if (eb == 0 && mb == 0) return a;
        // Subnormals have no hidden bit and an exponent of one.
        if (ea != 0) ma |= HiddenBit; else ea = 1;
        if (eb != 0) mb |= HiddenBit; else eb = 1;
        ma = ma << GrsBits;
        mb = mb << GrsBits;
        if (ea > eb) begin
            mb = shift_sticky(mb, ea - eb);
            er = ea;
        end else begin
            ma = shift_sticky(ma, eb - ea);
            er = eb;
        end
        if (sa == sb) begin
            mr = ma + mb;
            sr = sa;
        end else begin
            if (ma >= mb) begin
                mr = ma - mb;
                sr = sa;
            end else begin
                mr = mb - ma;
                sr = sb;
            end
            // Exact cancellation always gives plus zero.
            if (mr == 0) return 64'd0;
        end
        return round_to_word(sr, er, mr);
    endfunction

    // Builds an operand whose exponent is mostly in the common range, with a
    // fair share of zeros, subnormals, the largest finite values and specials.
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        int          sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 19);
        case (sel)
            0: v[62:52] = 11'd0;
            1: v[62:52] = 11'h7FF;
            2: v[62:52] = 11'h7FE;
            3: v[62:0]  = 63'd0;
            4: v[62:52] = 11'($urandom_range(0, 3));
            default: v[62:52] = 11'($urandom_range(900, 1150));
        endcase
        return v;
    endfunction

    // Issues one command word and records what the sum must be. The word is
    // held until an edge with busy low takes it; gaps come in random bursts
    // unless quiet is set.
    task automatic issue_word(input t_op op, input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] sum_word, input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_sums.push_back(sum_word);
    endtask

    // Result checker: the receiver always takes the word in its strobe cycle.
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_done) begin
            if (pending_sums.size() == 0) begin
                $error("sum_bits: no result expected, actual %h", o_sum_bits);
                fail_count++;
            end else begin
                want = pending_sums.pop_front();
                if (o_sum_bits !== want) begin
                    $error("sum_bits: expected %h, actual %h", want, o_sum_bits);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: the directed table first, then random words.
    initial begin
        t_row        rows[$];
        t_row        r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sum_word;
        t_op         op;
        int          wait_cycles;
        rows = '{
            '{OP_ADD, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1, 64'h0},
            '{OP_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1,
              64'h8000_0000_0000_0000},
            '{OP_SUB, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1,
              64'h8000_0000_0000_0000},
            '{OP_SUB, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1, 64'h0},
            '{OP_ADD, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1,
              64'h7FF8_0000_0000_0000},
            '{OP_SUB, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b1,
              64'h7FF8_0000_0000_0000},
            '{OP_ADD, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1,
              64'hFFF0_0000_0000_0000},
            '{OP_ADD, 64'h7FF0_0000_0000_0001, 64'h7FF8_0000_0000_0000, 1'b1,
              64'h7FF0_0000_0000_0001},
            '{OP_SUB, 64'h3FF0_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
              64'hFFFF_FFFF_FFFF_FFFF},
            '{OP_ADD, 64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1,
              64'h7FF0_0000_0000_0000},
            '{OP_ADD, 64'h0000_0000_0000_0000, 64'hC000_0000_0000_0000, 1'b1,
              64'hC000_0000_0000_0000},
            '{OP_SUB, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1, 64'h0},
            '{OP_ADD, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1,
              64'h4000_0000_0000_0000},
            '{OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1,
              64'h7FF0_0000_0000_0000},
            '{OP_SUB, 64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1,
              64'hFFF0_0000_0000_0000},
            '{OP_ADD, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 1'b1,
              64'h0000_0000_0000_0002},
            '{OP_ADD, 64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 1'b1,
              64'h0010_0000_0000_0000},
            '{OP_SUB, 64'h0010_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1,
              64'h000F_FFFF_FFFF_FFFF},
            '{OP_ADD, 64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000, 1'b0, 64'h0},
            '{OP_ADD, 64'h3FF0_0000_0000_0001, 64'h3CA0_0000_0000_0000, 1'b0, 64'h0},
            '{OP_SUB, 64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
            '{OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1,
              64'hFFFF_FFFF_FFFF_FFFF},
            '{OP_SUB, 64'h4340_0000_0000_0000, 64'h3FF8_0000_0000_0000, 1'b0, 64'h0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            sum_word = r.has_sum ? r.sum : predict_sum(r.op, r.a, r.b);
            issue_word(r.op, r.a, r.b, sum_word, 1'b0);
        end

        // Random part; the last stretch runs with no gaps at all.
        for (int n = 0; n < 1850; n++) begin
            op = t_op'($urandom_range(0, 1));
            a  = rand_operand();
            // Often keep b close to a so that cancellation is exercised.
            if ($urandom_range(0, 3) == 0) begin
                b = a ^ 64'($urandom_range(0, 255));
                b[63] = 1'($urandom_range(0, 1));
            end else begin
                b = rand_operand();
            end
            issue_word(op, a, b, predict_sum(op, a, b), n >= 1650);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_sums.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            $error("sum_bits: %0d results never arrived", pending_sums.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
